// ===== src/vrt_pkg.sv =====
package vrt_pkg;

	// Fixed field widths.
	localparam int VOX_W     = 20;
	localparam int DIR_W     = 16;
	localparam int LEN_W     = 32;
	localparam int CROSS_W   = 40;
	localparam int SPACING_W = 28;
	localparam int FACE_W    = 3;
	localparam int STAT_W    = 3;
	localparam int AXIS_W    = 2;

	// Defaults for the top-level parameters.
	localparam int DEF_POS_FRAC_BITS = 12;
	localparam int DEF_DIR_FRAC_BITS = 14;
	localparam int DEF_COORD_BITS    = 32;

	localparam logic [SPACING_W-1:0] SPACING_MAX = '1;
	localparam logic [CROSS_W-1:0]   CROSS_MAX   = '1;

	typedef logic [STAT_W-1:0] status_t;
	typedef logic [AXIS_W-1:0] axis_t;
	typedef logic [FACE_W-1:0] face_t;

	// Command codes.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Result status codes.
	localparam status_t STAT_PROBE  = 3'd0;
	localparam status_t STAT_HIT    = 3'd1;
	localparam status_t STAT_MISS   = 3'd2;
	localparam status_t STAT_NULL   = 3'd3;
	localparam status_t STAT_NO_RAY = 3'd4;

	// Entry axis codes.
	localparam axis_t AXIS_NONE = 2'd0;
	localparam axis_t AXIS_X    = 2'd1;
	localparam axis_t AXIS_Y    = 2'd2;
	localparam axis_t AXIS_Z    = 2'd3;

	localparam face_t FACE_NONE = 3'd0;

endpackage

// ===== src/vrt_div.sv =====
module vrt_div #(
	parameter int QW = 27,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [QW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [QW-1:0] quotient
);

	localparam int CNT_W = $clog2(QW + 1);

	logic [QW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             fits;

	// Restoring division, one quotient bit per cycle. The dividend shifts out
	// of the top of quo_q while quotient bits shift in at the bottom.
	always_comb begin
		trial = {rem_q, quo_q[QW-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[QW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/voxel_ray_traversal.sv =====
// Voxel ray walker (Amanatides-Woo 3D DDA) over a grid of unit cubes. A start
// item (cmd 0) loads a fixed-point ray and returns the voxel holding the origin
// as a probe, or a null result for an all-zero direction; each step item
// (cmd 1) answers whether the last reported voxel is occupied and returns a
// hit, the next voxel with its entry face, or a miss once the next crossing
// lies beyond ray_length, and a no-ray result when no ray is active. One item
// is in work at a time and in_ready is high only while the block waits for an
// item; a finished result may sit in the output register while the next item
// is taken. A step item passes through select, advance and emit states; a hit,
// a step without an active ray or a null ray goes straight to emit. A start
// item runs two divisions per moving axis on one shared restoring divider that
// produces one quotient bit per cycle; axes with zero direction skip them.
module voxel_ray_traversal #(
	parameter int POS_FRAC_BITS = vrt_pkg::DEF_POS_FRAC_BITS,
	parameter int DIR_FRAC_BITS = vrt_pkg::DEF_DIR_FRAC_BITS,
	parameter int COORD_BITS    = vrt_pkg::DEF_COORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic signed [COORD_BITS-1:0]        origin_x,
	input  logic signed [COORD_BITS-1:0]        origin_y,
	input  logic signed [COORD_BITS-1:0]        origin_z,
	input  logic signed [vrt_pkg::DIR_W-1:0]    dir_x,
	input  logic signed [vrt_pkg::DIR_W-1:0]    dir_y,
	input  logic signed [vrt_pkg::DIR_W-1:0]    dir_z,
	input  logic [vrt_pkg::LEN_W-1:0]           ray_length,
	input  logic                                occupied,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [vrt_pkg::VOX_W-1:0]    voxel_x,
	output logic signed [vrt_pkg::VOX_W-1:0]    voxel_y,
	output logic signed [vrt_pkg::VOX_W-1:0]    voxel_z,
	output logic [vrt_pkg::AXIS_W-1:0]          entry_axis,
	output logic                                entry_negative,
	output logic [vrt_pkg::STAT_W-1:0]          status
);

	import vrt_pkg::*;

	localparam int QW       = POS_FRAC_BITS + DIR_FRAC_BITS + 1;
	localparam int SP_SHIFT = POS_FRAC_BITS + DIR_FRAC_BITS;
	localparam int EXT_W    = (COORD_BITS > POS_FRAC_BITS + VOX_W) ?
		COORD_BITS : POS_FRAC_BITS + VOX_W;
	localparam logic [POS_FRAC_BITS:0] ONE_POS = {1'b1, {POS_FRAC_BITS{1'b0}}};
	localparam logic [QW-1:0] SP_DIVIDEND = QW'(1) << SP_SHIFT;
	localparam axis_t LAST_AX = 2'd2;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DIV_SP  = 3'd1;
	localparam logic [2:0] ST_WAIT_SP = 3'd2;
	localparam logic [2:0] ST_DIV_NC  = 3'd3;
	localparam logic [2:0] ST_WAIT_NC = 3'd4;
	localparam logic [2:0] ST_SEL     = 3'd5;
	localparam logic [2:0] ST_ADV     = 3'd6;
	localparam logic [2:0] ST_EMIT    = 3'd7;

	// Control state.
	logic [2:0] state_q;
	logic       walking_q;
	axis_t      ax_q;
	logic       out_valid_q;

	// Ray state.
	logic signed [VOX_W-1:0] cur_q    [3];
	logic [CROSS_W-1:0]      nc_q     [3];
	logic [SPACING_W-1:0]    sp_q     [3];
	logic                    move_q   [3];
	logic                    neg_q    [3];
	logic [DIR_W-1:0]        mag_q    [3];
	logic [POS_FRAC_BITS:0]  dist_q   [3];
	logic [LEN_W-1:0]        t_limit_q;
	face_t                   last_face_q;
	axis_t                   sel_q;
	face_t                   res_face_q;
	status_t                 res_status_q;

	// Output register.
	logic signed [VOX_W-1:0] out_vox_q [3];
	face_t                   out_face_q;
	status_t                 out_status_q;

	// Input decode.
	logic signed [COORD_BITS-1:0] org_a  [3];
	logic signed [DIR_W-1:0]      dir_a  [3];
	logic signed [EXT_W-1:0]      ext_a  [3];
	logic [POS_FRAC_BITS-1:0]     frac_a [3];
	logic [VOX_W-1:0]             vox_a  [3];
	logic [DIR_W-1:0]             mag_a  [3];
	logic [POS_FRAC_BITS:0]       dist_a [3];
	logic                         accept;
	logic                         null_ray;
	logic                         emit_load;

	// Divider hookup.
	logic                 div_start;
	logic [QW-1:0]        div_dividend;
	logic                 div_done;
	logic [QW-1:0]        div_quo;
	logic [63:0]          quo_wide;
	logic [SPACING_W-1:0] sp_sat;
	logic [CROSS_W-1:0]   nc_sat;

	// Step datapath.
	axis_t            sel_next;
	logic             miss;
	logic [CROSS_W:0] nc_sum;
	logic [CROSS_W-1:0] nc_adv;
	face_t            face_adv;

	always_comb begin
		org_a[0] = origin_x;
		org_a[1] = origin_y;
		org_a[2] = origin_z;
		dir_a[0] = dir_x;
		dir_a[1] = dir_y;
		dir_a[2] = dir_z;
		for (int i = 0; i < 3; i++) begin
			// Arithmetic shift of the sign-extended origin is a true floor.
			ext_a[i]  = EXT_W'(org_a[i]);
			vox_a[i]  = ext_a[i][POS_FRAC_BITS +: VOX_W];
			frac_a[i] = org_a[i][POS_FRAC_BITS-1:0];
			if (dir_a[i][DIR_W-1]) begin
				mag_a[i]  = DIR_W'(~dir_a[i] + 1'b1);
				dist_a[i] = (frac_a[i] == '0) ? ONE_POS : {1'b0, frac_a[i]};
			end else begin
				mag_a[i]  = dir_a[i];
				dist_a[i] = ONE_POS - {1'b0, frac_a[i]};
			end
		end
	end

	assign accept    = in_valid && in_ready;
	assign null_ray  = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == ST_IDLE);

	// Only the first of the two divisions of an axis uses the constant dividend.
	assign div_start    = ((state_q == ST_DIV_SP) && move_q[ax_q]) || (state_q == ST_DIV_NC);
	assign div_dividend = (state_q == ST_DIV_SP) ? SP_DIVIDEND :
		(QW'(dist_q[ax_q]) << DIR_FRAC_BITS);

	vrt_div #(
		.QW(QW),
		.DW(DIR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (mag_q[ax_q]),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		quo_wide = 64'(div_quo);
		sp_sat   = (quo_wide > 64'(SPACING_MAX)) ? SPACING_MAX : quo_wide[SPACING_W-1:0];
		nc_sat   = (quo_wide > 64'(CROSS_MAX)) ? CROSS_MAX : quo_wide[CROSS_W-1:0];
	end

	// x wins only when strictly below both others, then y when below z.
	always_comb begin
		if (nc_q[0] < nc_q[1]) begin
			sel_next = (nc_q[0] < nc_q[2]) ? 2'd0 : 2'd2;
		end else begin
			sel_next = (nc_q[1] < nc_q[2]) ? 2'd1 : 2'd2;
		end
		miss     = nc_q[sel_q] > CROSS_W'(t_limit_q);
		nc_sum   = {1'b0, nc_q[sel_q]} + (CROSS_W + 1)'(sp_q[sel_q]);
		nc_adv   = nc_sum[CROSS_W] ? CROSS_MAX : nc_sum[CROSS_W-1:0];
		face_adv = {move_q[sel_q] && !neg_q[sel_q], sel_q + 2'd1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			walking_q   <= 1'b0;
			ax_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_START) begin
							if (null_ray) begin
								walking_q <= 1'b0;
								state_q   <= ST_EMIT;
							end else begin
								walking_q <= 1'b1;
								ax_q      <= '0;
								state_q   <= ST_DIV_SP;
							end
						end else if (!walking_q) begin
							state_q <= ST_EMIT;
						end else if (occupied) begin
							walking_q <= 1'b0;
							state_q   <= ST_EMIT;
						end else begin
							state_q <= ST_SEL;
						end
					end
				end
				ST_DIV_SP: begin
					if (move_q[ax_q]) begin
						state_q <= ST_WAIT_SP;
					end else if (ax_q == LAST_AX) begin
						state_q <= ST_EMIT;
					end else begin
						ax_q <= ax_q + 2'd1;
					end
				end
				ST_WAIT_SP: begin
					if (div_done) begin
						state_q <= ST_DIV_NC;
					end
				end
				ST_DIV_NC: begin
					state_q <= ST_WAIT_NC;
				end
				ST_WAIT_NC: begin
					if (div_done) begin
						if (ax_q == LAST_AX) begin
							state_q <= ST_EMIT;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= ST_DIV_SP;
						end
					end
				end
				ST_SEL: begin
					state_q <= ST_ADV;
				end
				ST_ADV: begin
					if (miss) begin
						walking_q <= 1'b0;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_START) begin
						last_face_q <= FACE_NONE;
						res_face_q  <= FACE_NONE;
						if (null_ray) begin
							for (int i = 0; i < 3; i++) begin
								cur_q[i] <= '0;
							end
							res_status_q <= STAT_NULL;
						end else begin
							for (int i = 0; i < 3; i++) begin
								cur_q[i]  <= vox_a[i];
								move_q[i] <= (dir_a[i] != '0);
								neg_q[i]  <= dir_a[i][DIR_W-1];
								mag_q[i]  <= mag_a[i];
								dist_q[i] <= dist_a[i];
							end
							t_limit_q    <= ray_length;
							res_status_q <= STAT_PROBE;
						end
					end else if (!walking_q) begin
						res_face_q   <= FACE_NONE;
						res_status_q <= STAT_NO_RAY;
					end else if (occupied) begin
						res_face_q   <= last_face_q;
						res_status_q <= STAT_HIT;
					end
				end
			end
			ST_DIV_SP: begin
				// A still axis never wins before the ray length ends the walk.
				if (!move_q[ax_q]) begin
					sp_q[ax_q] <= SPACING_MAX;
					nc_q[ax_q] <= CROSS_MAX;
				end
			end
			ST_WAIT_SP: begin
				if (div_done) begin
					sp_q[ax_q] <= sp_sat;
				end
			end
			ST_WAIT_NC: begin
				if (div_done) begin
					nc_q[ax_q] <= nc_sat;
				end
			end
			ST_SEL: begin
				sel_q <= sel_next;
			end
			ST_ADV: begin
				if (miss) begin
					res_face_q   <= FACE_NONE;
					res_status_q <= STAT_MISS;
				end else begin
					if (move_q[sel_q]) begin
						cur_q[sel_q] <= neg_q[sel_q] ? cur_q[sel_q] - VOX_W'(1) :
							cur_q[sel_q] + VOX_W'(1);
					end
					nc_q[sel_q]  <= nc_adv;
					last_face_q  <= face_adv;
					res_face_q   <= face_adv;
					res_status_q <= STAT_PROBE;
				end
			end
			ST_EMIT: begin
				if (emit_load) begin
					for (int i = 0; i < 3; i++) begin
						out_vox_q[i] <= (res_status_q == STAT_NO_RAY) ? '0 : cur_q[i];
					end
					out_face_q   <= res_face_q;
					out_status_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign voxel_x        = out_vox_q[0];
	assign voxel_y        = out_vox_q[1];
	assign voxel_z        = out_vox_q[2];
	assign entry_axis     = out_face_q[AXIS_W-1:0];
	assign entry_negative = out_face_q[FACE_W-1];
	assign status         = out_status_q;

endmodule

// ===== src/vrt_checker.sv =====
module vrt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [vrt_pkg::VOX_W-1:0] voxel_x,
	input logic signed [vrt_pkg::VOX_W-1:0] voxel_y,
	input logic signed [vrt_pkg::VOX_W-1:0] voxel_z,
	input logic [vrt_pkg::AXIS_W-1:0]       entry_axis,
	input logic                             entry_negative,
	input logic [vrt_pkg::STAT_W-1:0]       status
);

	import vrt_pkg::*;

	// Every item keeps the block busy in the cycle after it is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on two consecutive cycles");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(voxel_x)
			&& $stable(voxel_y) && $stable(voxel_z) && $stable(entry_axis))
		else $error("stalled result changed");

	// A null ray and a step without a ray report an all-zero position and face.
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_NULL || status == STAT_NO_RAY) |->
			voxel_x == '0 && voxel_y == '0 && voxel_z == '0
			&& entry_axis == AXIS_NONE && !entry_negative)
		else $error("null or inactive result has nonzero fields");

	a_miss_face: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_MISS |-> entry_axis == AXIS_NONE && !entry_negative)
		else $error("miss reports an entry face");

	a_neg_needs_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_negative |-> entry_axis != AXIS_NONE)
		else $error("negative face flag without an entry axis");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.voxel_x        (voxel_x),
	.voxel_y        (voxel_y),
	.voxel_z        (voxel_z),
	.entry_axis     (entry_axis),
	.entry_negative (entry_negative),
	.status         (status)
);

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import vrt_pkg::*;

	localparam int PFB = DEF_POS_FRAC_BITS;
	localparam int DFB = DEF_DIR_FRAC_BITS;
	localparam longint ONE_UNIT = longint'(1) << PFB;
	localparam int RANDOM_ITEMS = 700;
	localparam int DRAIN_CYCLES = 200;
	localparam axis_t AXIS_OF [3] = '{AXIS_X, AXIS_Y, AXIS_Z};

	typedef struct packed {
		logic [VOX_W-1:0] vx;
		logic [VOX_W-1:0] vy;
		logic [VOX_W-1:0] vz;
		axis_t            axis;
		logic             neg;
		status_t          stat;
	} vox_res_t;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dz;
		logic [31:0]        len;
		logic               occ;
		logic               typed;
		vox_res_t           want;
	} stim_t;

	localparam vox_res_t NO_RAY_RES = '{20'h0, 20'h0, 20'h0, AXIS_NONE, 1'b0, STAT_NO_RAY};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_START;
	logic signed [31:0] origin_x = '0;
	logic signed [31:0] origin_y = '0;
	logic signed [31:0] origin_z = '0;
	logic signed [DIR_W-1:0] dir_x = '0;
	logic signed [DIR_W-1:0] dir_y = '0;
	logic signed [DIR_W-1:0] dir_z = '0;
	logic [LEN_W-1:0] ray_length = '0;
	logic occupied = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [VOX_W-1:0] voxel_x;
	logic signed [VOX_W-1:0] voxel_y;
	logic signed [VOX_W-1:0] voxel_z;
	logic [AXIS_W-1:0] entry_axis;
	logic entry_negative;
	logic [STAT_W-1:0] status;

	voxel_ray_traversal dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Walker state as the block should hold it.
	logic [VOX_W-1:0]     p_cur [3];
	logic [CROSS_W-1:0]   p_cross [3];
	logic [SPACING_W-1:0] p_spacing [3];
	logic                 p_moves [3];
	logic                 p_back [3];
	logic [LEN_W-1:0]     p_limit;
	axis_t                p_face_axis;
	logic                 p_face_neg;
	logic                 p_walking;

	vox_res_t voxel_reports [$];
	int errors = 0;
	bit calm = 1'b0;

	initial begin
		for (int a = 0; a < 3; a++) begin
			p_cur[a] = '0;
			p_cross[a] = '0;
			p_spacing[a] = '0;
			p_moves[a] = 1'b0;
			p_back[a] = 1'b0;
		end
		p_limit = '0;
		p_face_axis = AXIS_NONE;
		p_face_neg = 1'b0;
		p_walking = 1'b0;
	end

	function automatic void setup_axis(int a, logic signed [31:0] org, logic signed [15:0] d);
		longint mag;
		longint span;
		longint sp;
		longint nc;
		p_cur[a] = VOX_W'(org >>> PFB);
		if (d == 0) begin
			p_spacing[a] = SPACING_MAX;
			p_cross[a] = CROSS_MAX;
			p_moves[a] = 1'b0;
			p_back[a] = 1'b0;
		end else begin
			mag = (d < 0) ? -longint'(d) : longint'(d);
			if (d > 0)
				span = ONE_UNIT - longint'(org[PFB-1:0]);
			else
				span = (org[PFB-1:0] == 0) ? ONE_UNIT : longint'(org[PFB-1:0]);
			sp = (longint'(1) << (PFB + DFB)) / mag;
			nc = (span << DFB) / mag;
			p_spacing[a] = (sp > longint'(SPACING_MAX)) ? SPACING_MAX : SPACING_W'(sp);
			p_cross[a] = (nc > longint'(CROSS_MAX)) ? CROSS_MAX : CROSS_W'(nc);
			p_moves[a] = 1'b1;
			p_back[a] = (d < 0);
		end
	endfunction

	function automatic vox_res_t walk_ray(stim_t s);
		vox_res_t r;
		int a;
		logic [CROSS_W:0] sum;
		r = '0;
		if (s.cmd == CMD_START) begin
			if (s.dx == 0 && s.dy == 0 && s.dz == 0) begin
				p_walking = 1'b0;
				for (int i = 0; i < 3; i++)
					p_cur[i] = '0;
				p_face_axis = AXIS_NONE;
				p_face_neg = 1'b0;
				r.stat = STAT_NULL;
			end else begin
				setup_axis(0, s.ox, s.dx);
				setup_axis(1, s.oy, s.dy);
				setup_axis(2, s.oz, s.dz);
				p_limit = s.len;
				p_face_axis = AXIS_NONE;
				p_face_neg = 1'b0;
				p_walking = 1'b1;
				r.stat = STAT_PROBE;
			end
		end else if (!p_walking) begin
			return NO_RAY_RES;
		end else if (s.occ) begin
			p_walking = 1'b0;
			r.axis = p_face_axis;
			r.neg = p_face_neg;
			r.stat = STAT_HIT;
		end else begin
			// Strict compares: x wins only below both, y only below z.
			if (p_cross[0] < p_cross[1])
				a = (p_cross[0] < p_cross[2]) ? 0 : 2;
			else
				a = (p_cross[1] < p_cross[2]) ? 1 : 2;
			if (p_cross[a] > CROSS_W'(p_limit)) begin
				p_walking = 1'b0;
				r.stat = STAT_MISS;
			end else begin
				if (p_moves[a])
					p_cur[a] = p_back[a] ? p_cur[a] - 1'b1 : p_cur[a] + 1'b1;
				sum = {1'b0, p_cross[a]} + p_spacing[a];
				p_cross[a] = sum[CROSS_W] ? CROSS_MAX : sum[CROSS_W-1:0];
				p_face_axis = AXIS_OF[a];
				p_face_neg = p_moves[a] && !p_back[a];
				r.axis = p_face_axis;
				r.neg = p_face_neg;
				r.stat = STAT_PROBE;
			end
		end
		r.vx = p_cur[0];
		r.vy = p_cur[1];
		r.vz = p_cur[2];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic stim_t scramble();
		stim_t s;
		s = '0;
		s.cmd = 1'($urandom);
		s.ox = $urandom;
		s.oy = $urandom;
		s.oz = $urandom;
		s.dx = 16'($urandom);
		s.dy = 16'($urandom);
		s.dz = 16'($urandom);
		s.len = $urandom;
		s.occ = 1'($urandom);
		return s;
	endfunction

	function automatic stim_t ray_item(logic signed [31:0] ox, logic signed [31:0] oy,
			logic signed [31:0] oz, logic signed [15:0] dx, logic signed [15:0] dy,
			logic signed [15:0] dz, logic [31:0] len, logic occ);
		stim_t s;
		s = '0;
		s.cmd = CMD_START;
		s.ox = ox;
		s.oy = oy;
		s.oz = oz;
		s.dx = dx;
		s.dy = dy;
		s.dz = dz;
		s.len = len;
		s.occ = occ;
		return s;
	endfunction

	function automatic stim_t step_item(logic occ);
		stim_t s;
		s = '0;
		s.cmd = CMD_STEP;
		s.occ = occ;
		return s;
	endfunction

	function automatic stim_t pinned(stim_t s, vox_res_t want);
		s.typed = 1'b1;
		s.want = want;
		return s;
	endfunction

	function automatic logic [31:0] rand_origin();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 32'($urandom_range(0, 32'(64 * ONE_UNIT)) - 32 * ONE_UNIT);
		if (r < 60)
			return 32'(($urandom_range(0, 64) - 32) * ONE_UNIT);
		return $urandom;
	endfunction

	function automatic logic [15:0] rand_dir();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 15)
			return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
		if (r < 18)
			return 16'($urandom);
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	task automatic send_item(stim_t s);
		int gap;
		vox_res_t r;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= s.cmd;
		origin_x <= s.ox;
		origin_y <= s.oy;
		origin_z <= s.oz;
		dir_x <= s.dx;
		dir_y <= s.dy;
		dir_z <= s.dz;
		ray_length <= s.len;
		occupied <= s.occ;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		r = walk_ray(s);
		voxel_reports.push_back(s.typed ? s.want : r);
	endtask

	task automatic cmp(string what, logic [VOX_W-1:0] want, logic [VOX_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
		end
	endtask

	// Result side: random stalls, then compare each accepted item in order.
	int stall_left = 0;
	always @(posedge clk) begin
		vox_res_t want;
		if (out_valid && out_ready) begin
			if (voxel_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected result expected none got %0h %0h %0h %0h %0h %0h",
					$time, voxel_x, voxel_y, voxel_z, entry_axis, entry_negative, status);
			end else begin
				want = voxel_reports.pop_front();
				cmp("voxel_x", want.vx, voxel_x);
				cmp("voxel_y", want.vy, voxel_y);
				cmp("voxel_z", want.vz, voxel_z);
				cmp("entry_axis", want.axis, entry_axis);
				cmp("entry_negative", want.neg, entry_negative);
				cmp("status", want.stat, status);
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	initial begin
		stim_t plan [$];
		stim_t s;
		int n;
		int rand_sent;
		int r;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Nothing active yet, then a null ray.
		plan.push_back(pinned(step_item(1'b0), NO_RAY_RES));
		plan.push_back(pinned(step_item(1'b1), NO_RAY_RES));
		plan.push_back(pinned(ray_item(32'sh12345, -32'sd77, 32'sh4000, '0, '0, '0, '1, 1'b0),
			'{20'h0, 20'h0, 20'h0, AXIS_NONE, 1'b0, STAT_NULL}));
		plan.push_back(pinned(step_item(1'b0), NO_RAY_RES));
		// Negative exact integer and negative fraction floor correctly.
		plan.push_back(pinned(ray_item(32'sh3800, -32'sd8192, -32'sd1024,
			16'sd16384, '0, '0, 32'h10000, 1'b0),
			'{20'h00003, 20'hFFFFE, 20'hFFFFF, AXIS_NONE, 1'b0, STAT_PROBE}));
		plan.push_back(step_item(1'b0));
		plan.push_back(step_item(1'b0));
		plan.push_back(step_item(1'b1));
		plan.push_back(pinned(step_item(1'b0), NO_RAY_RES));
		// Largest origin with the out-of-range direction on every axis.
		plan.push_back(pinned(ray_item(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			-16'sd32768, -16'sd32768, -16'sd32768, '1, 1'b0),
			'{20'h7FFFF, 20'h7FFFF, 20'h7FFFF, AXIS_NONE, 1'b0, STAT_PROBE}));
		repeat (4) plan.push_back(step_item(1'b0));
		// Smallest origin and a zero ray length.
		plan.push_back(pinned(ray_item(32'sh80000000, 32'sh80000000, 32'sh80000000,
			16'sd16384, 16'sd16384, -16'sd16384, 32'h0, 1'b0),
			'{20'h80000, 20'h80000, 20'h80000, AXIS_NONE, 1'b0, STAT_PROBE}));
		plan.push_back(pinned(step_item(1'b0),
			'{20'h80000, 20'h80000, 20'h80000, AXIS_NONE, 1'b0, STAT_MISS}));
		// Tiny directions give the largest spacing.
		plan.push_back(pinned(ray_item('0, '0, '0, 16'sd1, -16'sd1, '0, '1, 1'b0),
			'{20'h0, 20'h0, 20'h0, AXIS_NONE, 1'b0, STAT_PROBE}));
		plan.push_back(step_item(1'b0));
		plan.push_back(step_item(1'b0));
		// Restart while walking; all three crossings tie.
		plan.push_back(pinned(ray_item(32'sh1000, 32'sh2000, 32'sh3000,
			16'sd8192, 16'sd8192, 16'sd8192, 32'h8000, 1'b1),
			'{20'h1, 20'h2, 20'h3, AXIS_NONE, 1'b0, STAT_PROBE}));
		plan.push_back(step_item(1'b0));
		plan.push_back(step_item(1'b0));
		plan.push_back(ray_item(-32'sd1, 32'sh7FF, 32'sh801, -16'sd16384, '0, '0, 32'h0, 1'b0));
		plan.push_back(step_item(1'b0));

		foreach (plan[i])
			send_item(plan[i]);

		rand_sent = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			calm = ((rand_sent / 80) % 4) == 3;
			r = $urandom_range(0, 99);
			if (r < 85) begin
				s = scramble();
				s.cmd = CMD_START;
				s.ox = rand_origin();
				s.oy = rand_origin();
				s.oz = rand_origin();
				s.dx = rand_dir();
				s.dy = rand_dir();
				s.dz = rand_dir();
				r = $urandom_range(0, 99);
				if (r < 10)
					s.len = '0;
				else if (r >= 20)
					s.len = $urandom_range(0, 32'(40 * ONE_UNIT));
				send_item(s);
				rand_sent++;
				n = $urandom_range(1, 40);
				for (int i = 0; i < n && p_walking; i++) begin
					s = scramble();
					s.cmd = CMD_STEP;
					s.occ = ($urandom_range(0, 19) == 0);
					send_item(s);
					rand_sent++;
				end
				if (!p_walking && $urandom_range(0, 3) == 0) begin
					s = scramble();
					s.cmd = CMD_STEP;
					send_item(s);
					rand_sent++;
				end
			end else begin
				send_item(scramble());
				rand_sent++;
			end
		end
		in_valid <= 1'b0;

		while (voxel_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
